[sv/whf_pkg.sv]
// Shared constants, codes and helper functions for the waypoint heading follower.
package whf_pkg;

  localparam int unsigned MAX_WAYPOINTS = 8;
  localparam int unsigned SLOT_W  = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int unsigned COUNT_W = $clog2(MAX_WAYPOINTS + 1);

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned STEP_W = 5;

  // input item codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_SPARE  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_GAIN_P    = 3'd0;
  localparam logic [2:0] CFG_CRUISE    = 3'd1;
  localparam logic [2:0] CFG_TURN      = 3'd2;
  localparam logic [2:0] CFG_RADIUS    = 3'd3;
  localparam logic [2:0] CFG_TOLERANCE = 3'd4;
  localparam logic [2:0] CFG_HALT      = 3'd5;

  // reported phase codes
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_ROTATE  = 2'd1;
  localparam logic [1:0] PH_DRIVE   = 2'd2;
  localparam logic [1:0] PH_ARRIVED = 2'd3;

  localparam logic [15:0] GAIN_P_RST    = 16'd128;
  localparam logic [14:0] CRUISE_RST    = 15'd1229;
  localparam logic [14:0] TURN_RST      = 15'd1638;
  localparam logic [15:0] RADIUS_RST    = 16'd6554;
  localparam logic [7:0]  TOLERANCE_RST = 8'd12;

  localparam logic signed [17:0] HALF_TURN    = 18'sd11520;
  localparam logic signed [17:0] FULL_TURN    = 18'sd23040;
  localparam logic        [15:0] QUARTER_TURN = 16'd5760;
  localparam logic        [31:0] DEG2RAD_Q24  = 32'd292818;

  // atan(2^-i) in Q16 degrees
  function automatic logic [21:0] atan_q16(input logic [STEP_W-1:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  // heading error in 1/64 degree, wrapped into a half turn, optionally flipped
  function automatic logic signed [15:0] heading_err(input logic signed [8:0]  bdeg,
                                                     input logic signed [14:0] hdg,
                                                     input logic               back);
    logic signed [17:0] v;
    v = 18'(signed'({bdeg, 6'b0})) - 18'(hdg);
    if (v > HALF_TURN) begin
      v = v - FULL_TURN;
    end else if (v < -HALF_TURN) begin
      v = v + FULL_TURN;
    end
    if (back) begin
      v = HALF_TURN - v;
      if (v > HALF_TURN) begin
        v = v - FULL_TURN;
      end else if (v < -HALF_TURN) begin
        v = v + FULL_TURN;
      end
    end
    return v[15:0];
  endfunction

endpackage

[sv/whf_cordic.sv]
// Iterative first-quadrant vectoring CORDIC giving whole degrees 0..90.
module whf_cordic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] ax_i,
  input  logic [32:0] ay_i,
  output logic        done_o,
  output logic [6:0]  deg_o
);

  localparam int unsigned STEP_W = whf_pkg::STEP_W;

  logic signed [35:0] x_q, y_q, xs, ys, ny;
  logic signed [24:0] z_q, zc, zr, ang;
  logic [whf_pkg::STEP_W-1:0] step_q;
  logic busy_q, done_q;

  always_comb begin
    xs  = x_q >>> step_q;
    ny  = -y_q;
    ys  = y_q[35] ? -(ny >>> step_q) : (y_q >>> step_q);
    ang = signed'({3'b0, whf_pkg::atan_q16(step_q)});
    zc  = z_q[24] ? 25'sd0 : z_q;
    zr  = (zc + 25'sd32768) >>> 16;
    deg_o = (zr > 25'sd90) ? 7'd90 : zr[6:0];
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        x_q    <= signed'({3'b0, ax_i});
        y_q    <= signed'({3'b0, ay_i});
        z_q    <= '0;
        step_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (y_q > 36'sd0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + ang;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - ang;
        end
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(whf_pkg::CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/waypoint_heading_follower.sv]
// Waypoint heading follower top level: sequencer, waypoint memory and shared multiplier.
//
// Every input transfer yields exactly one result transfer. Append, clear and
// unused codes go straight to the output state; so does a pose tick in halt
// mode or with an empty table. A real tick runs the 16-step atan CORDIC, then
// either rotates, or steps through the multiplier states and arrives or
// drives; a new waypoint is first read from memory in ST_READ and ST_TARGET.
// One 32x32 multiplier, shared by states ST_MX to ST_MM, does the arrival
// test and the proportional heading term. in_ready_o is high only while the
// sequencer is idle; a finished result waits in the output register while the
// next item is taken. Configuration writes are single-cycle and must be made
// while idle. The waypoint table holds 8 entries; slots never appended read as
// undefined and are never selected.
module waypoint_heading_follower (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [14:0] heading_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] linear_cmd_o,
  output logic signed [15:0] angular_cmd_o,
  output logic [1:0]         phase_o,
  output logic [2:0]         target_slot_o,
  output logic               reversing_o
);

  localparam int unsigned SLOT_W  = whf_pkg::SLOT_W;
  localparam int unsigned COUNT_W = whf_pkg::COUNT_W;
  localparam int unsigned MAX_WP  = whf_pkg::MAX_WAYPOINTS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_TARGET, ST_DIFF, ST_START, ST_WAIT, ST_ERR,
    ST_MX, ST_MY, ST_MR, ST_MP, ST_MM, ST_OUT
  } state_e;

  typedef enum logic [1:0] {TP_SELECT, TP_ROTATE, TP_DRIVE} travel_e;

  state_e  state_q;
  travel_e travel_q;

  // configuration
  logic [15:0] gain_p_q, radius_q;
  logic [14:0] cruise_q, turn_q;
  logic [7:0]  tol_q;
  logic        halt_q;

  // control state
  logic [COUNT_W-1:0] count_q;
  logic [SLOT_W-1:0]  next_slot_q, cur_slot_q, sel_slot;
  logic [COUNT_W-1:0] sel_ext, sel_inc;
  logic               back_q, select_q;

  // datapath
  logic signed [31:0] pos_x_q, pos_y_q, tgt_x_q, tgt_y_q;
  logic signed [14:0] hdg_q;
  logic signed [32:0] dx_q, dy_q;
  logic [32:0]        ax, ay;
  logic signed [15:0] e_q;
  logic [14:0]        e_abs_q;
  logic [32:0]        sum_q;
  logic [29:0]        pabs_q;
  logic signed [15:0] res_lin_q, res_ang_q;
  logic [1:0]         res_ph_q;

  // waypoint memory
  logic [63:0] wp_mem [MAX_WP];
  logic [63:0] rd_q;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  // cordic
  logic       cor_start, cor_done;
  logic [6:0] cor_deg;

  // bearing / error
  logic signed [8:0]  bdeg, adeg;
  logic signed [15:0] e_fwd, e_new;
  logic [15:0]        e_fwd_abs, e_new_abs;
  logic               bk_new, far;
  logic [13:0]        tol64;
  logic [63:0]        mag_sum;
  logic [37:0]        mag;
  logic               neg;
  logic signed [15:0] sat;
  logic [SLOT_W+2:0]  slot_ext;

  logic in_fire, do_append;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign do_append  = in_fire && (func_i == whf_pkg::FUNC_APPEND) &&
                      (count_q < COUNT_W'(MAX_WP));

  assign cor_start = (state_q == ST_START);

  whf_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .ax_i    (ax),
    .ay_i    (ay),
    .done_o  (cor_done),
    .deg_o   (cor_deg)
  );

  always_comb begin
    ax = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
    ay = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
    far = (ax[32:16] != 17'd0) || (ay[32:16] != 17'd0);

    // slot choice for a new waypoint
    sel_slot = (COUNT_W'(next_slot_q) < count_q) ? next_slot_q : '0;
    sel_ext  = COUNT_W'(sel_slot);
    sel_inc  = sel_ext + 1'b1;

    // bearing in whole degrees from the quadrant and special axes
    adeg = signed'({2'b0, cor_deg});
    if (dy_q == 33'sd0) begin
      bdeg = dx_q[32] ? -9'sd180 : 9'sd0;
    end else if (dx_q == 33'sd0) begin
      bdeg = dy_q[32] ? -9'sd90 : 9'sd90;
    end else if (!dx_q[32]) begin
      bdeg = dy_q[32] ? -adeg : adeg;
    end else begin
      bdeg = dy_q[32] ? (adeg - 9'sd180) : (9'sd180 - adeg);
    end

    e_fwd     = whf_pkg::heading_err(bdeg, hdg_q, 1'b0);
    e_fwd_abs = e_fwd[15] ? 16'(-e_fwd) : 16'(e_fwd);
    bk_new    = select_q ? (e_fwd_abs >= whf_pkg::QUARTER_TURN) : back_q;
    e_new     = whf_pkg::heading_err(bdeg, hdg_q, bk_new);
    e_new_abs = e_new[15] ? 16'(-e_new) : 16'(e_new);
    tol64     = {tol_q, 6'b0};

    case (state_q)
      ST_MX:   begin mul_a = {16'd0, ax[15:0]};   mul_b = {16'd0, ax[15:0]}; end
      ST_MY:   begin mul_a = {16'd0, ay[15:0]};   mul_b = {16'd0, ay[15:0]}; end
      ST_MR:   begin mul_a = {16'd0, radius_q};   mul_b = {16'd0, radius_q}; end
      ST_MP:   begin mul_a = {16'd0, gain_p_q};   mul_b = {17'd0, e_abs_q};  end
      ST_MM:   begin mul_a = {2'd0, pabs_q};      mul_b = whf_pkg::DEG2RAD_Q24; end
      default: begin mul_a = '0;                  mul_b = '0;                end
    endcase
    prod = mul_a * mul_b;

    // round half away from zero, apply sign, saturate
    mag_sum = prod + 64'd33554432;
    mag     = mag_sum[63:26];
    neg     = e_q[15] ^ back_q;
    if (neg) begin
      sat = (mag > 38'd32768) ? -16'sd32768 : 16'(-signed'({1'b0, mag[15:0]}));
    end else begin
      sat = (mag > 38'd32767) ? 16'sd32767 : signed'(mag[15:0]);
    end

    slot_ext = {3'b0, cur_slot_q};
  end

  // waypoint memory
  always_ff @(posedge clk_i) begin
    if (do_append) begin
      wp_mem[count_q[SLOT_W-1:0]] <= {pos_y_i, pos_x_i};
    end
    rd_q <= wp_mem[cur_slot_q];
  end

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= whf_pkg::GAIN_P_RST;
      cruise_q <= whf_pkg::CRUISE_RST;
      turn_q   <= whf_pkg::TURN_RST;
      radius_q <= whf_pkg::RADIUS_RST;
      tol_q    <= whf_pkg::TOLERANCE_RST;
      halt_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        whf_pkg::CFG_GAIN_P:    gain_p_q <= cfg_data_i;
        whf_pkg::CFG_CRUISE:    cruise_q <= cfg_data_i[14:0];
        whf_pkg::CFG_TURN:      turn_q   <= cfg_data_i[14:0];
        whf_pkg::CFG_RADIUS:    radius_q <= cfg_data_i;
        whf_pkg::CFG_TOLERANCE: tol_q    <= cfg_data_i[7:0];
        whf_pkg::CFG_HALT:      halt_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      travel_q      <= TP_SELECT;
      count_q       <= '0;
      next_slot_q   <= '0;
      cur_slot_q    <= '0;
      back_q        <= 1'b0;
      select_q      <= 1'b0;
      tgt_x_q       <= '0;
      tgt_y_q       <= '0;
      out_valid_o   <= 1'b0;
      linear_cmd_o  <= '0;
      angular_cmd_o <= '0;
      phase_o       <= whf_pkg::PH_IDLE;
      target_slot_o <= '0;
      reversing_o   <= 1'b0;
    end else begin
      // ST_OUT refills the output register itself
      if (out_valid_o && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            pos_x_q   <= pos_x_i;
            pos_y_q   <= pos_y_i;
            hdg_q     <= heading_i;
            res_lin_q <= '0;
            res_ang_q <= '0;
            res_ph_q  <= whf_pkg::PH_IDLE;
            select_q  <= 1'b0;
            state_q   <= ST_OUT;
            case (func_i)
              whf_pkg::FUNC_APPEND: begin
                if (do_append) count_q <= count_q + 1'b1;
              end
              whf_pkg::FUNC_CLEAR: begin
                count_q     <= '0;
                next_slot_q <= '0;
                travel_q    <= TP_SELECT;
                back_q      <= 1'b0;
              end
              whf_pkg::FUNC_TICK: begin
                if (!halt_q && count_q != '0) begin
                  if (travel_q == TP_SELECT) begin
                    cur_slot_q  <= sel_slot;
                    next_slot_q <= (sel_inc >= count_q) ? '0 : sel_inc[SLOT_W-1:0];
                    select_q    <= 1'b1;
                    state_q     <= ST_READ;
                  end else begin
                    state_q <= ST_DIFF;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_READ:   state_q <= ST_TARGET;
        ST_TARGET: begin
          tgt_x_q <= rd_q[31:0];
          tgt_y_q <= rd_q[63:32];
          state_q <= ST_DIFF;
        end
        ST_DIFF: begin
          dx_q    <= 33'(tgt_x_q) - 33'(pos_x_q);
          dy_q    <= 33'(tgt_y_q) - 33'(pos_y_q);
          state_q <= ST_START;
        end
        ST_START: state_q <= ST_WAIT;
        ST_WAIT:  if (cor_done) state_q <= ST_ERR;
        ST_ERR: begin
          back_q  <= bk_new;
          e_q     <= e_new;
          e_abs_q <= e_new_abs[14:0];
          if (select_q || travel_q == TP_ROTATE) begin
            if (e_new_abs < {2'b0, tol64}) begin
              travel_q <= TP_DRIVE;
              state_q  <= ST_MX;
            end else begin
              travel_q <= TP_ROTATE;
              res_ph_q <= whf_pkg::PH_ROTATE;
              if (e_new == 16'sd0) begin
                res_ang_q <= '0;
              end else if (e_new[15] ^ bk_new) begin
                res_ang_q <= -signed'({1'b0, turn_q});
              end else begin
                res_ang_q <= signed'({1'b0, turn_q});
              end
              state_q <= ST_OUT;
            end
          end else begin
            state_q <= ST_MX;
          end
        end
        ST_MX: begin
          sum_q   <= {1'b0, prod[31:0]};
          state_q <= ST_MY;
        end
        ST_MY: begin
          sum_q   <= sum_q + {1'b0, prod[31:0]};
          state_q <= ST_MR;
        end
        ST_MR: begin
          if (!far && sum_q < prod[32:0]) begin
            res_ph_q <= whf_pkg::PH_ARRIVED;
            travel_q <= TP_SELECT;
            state_q  <= ST_OUT;
          end else begin
            state_q <= ST_MP;
          end
        end
        ST_MP: begin
          pabs_q  <= prod[29:0];
          state_q <= ST_MM;
        end
        ST_MM: begin
          res_ph_q  <= whf_pkg::PH_DRIVE;
          res_ang_q <= sat;
          res_lin_q <= back_q ? -signed'({1'b0, cruise_q}) : signed'({1'b0, cruise_q});
          state_q   <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o   <= 1'b1;
            linear_cmd_o  <= res_lin_q;
            angular_cmd_o <= res_ang_q;
            phase_o       <= res_ph_q;
            target_slot_o <= slot_ext[2:0];
            reversing_o   <= back_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
